@@ hdl/fwbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwbc_pkg
// Shared types, codes, constants and arithmetic helpers of the bond current
// kernel: command word, configuration set, saturation and the logistic table.
// ----------------------------------------------------------------------------
package fwbc_pkg;

  typedef enum logic [1:0] {
    FN_LOAD_EIG = 2'd0,
    FN_LOAD_UP  = 2'd1,
    FN_LOAD_DN  = 2'd2,
    FN_QUERY    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_ZERO_TEMP   = 2'd0,
    CFG_INV_TEMP    = 2'd1,
    CFG_EIGEN_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OCC_MUL,
    ST_OCC_WR,
    ST_ISSUE,
    ST_DRAIN,
    ST_SAT,
    ST_SCALE,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    func_e              func;
    logic               ok;
    logic [5:0]         eig;
    logic [5:0]         sa;
    logic [5:0]         sb;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } cmd_t;

  typedef struct packed {
    logic        zero_temp;
    logic [31:0] inv_temp;
    logic [6:0]  eigen_count;
  } cfg_t;

  localparam logic [16:0]  OneQ16   = 17'd65536;
  localparam logic [16:0]  HalfQ16  = 17'd32768;
  localparam int           LutSize  = 256;
  localparam logic [127:0] ExpStep  = 128'd4034748382;

  typedef logic [16:0] lut_t [LutSize];

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd140737488355327;
    lo = -64'sd140737488355328;
    if (v > hi) begin
      return 48'sh7fffffffffff;
    end else if (v < lo) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

  // w[k] = round(65536*g/(2^32+g)), g stepping by e^(-1/16) in q0.32
  function automatic lut_t build_lut();
    lut_t         t;
    logic [127:0] g;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] rem;
    logic [127:0] prod;
    logic [16:0]  q;
    g = 128'd1 << 32;
    for (int k = 0; k < LutSize; k++) begin
      den = (128'd1 << 32) + g;
      num = (g << 16) + (den >> 1);
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[126:0], num[b]};
        if (rem >= den) begin
          rem = rem - den;
          if (b < 17) begin
            q[b] = 1'b1;
          end
        end
      end
      t[k] = q;
      prod = g * ExpStep;
      g    = (prod + (128'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam lut_t LogisticLut = build_lut();

endpackage
`default_nettype wire

@@ hdl/fermi_weighted_bond_current_kernel_core.sv @@
`default_nettype none
// an up or down load is written as it leaves the queue, an eigenvalue load via
// OCC_MUL and OCC_WR; a bond query issues its terms, drains, then passes SAT,
// SCALE and OUT to done_o, or skips to SAT with no terms; words go one after another
// throughput: one eigenstate term per cycle for both spins, set by the
// single sequenced read port pair of each eigenvector memory
// reset: step occupation, beta 1.0, 64 states; stores hold no reset; done_o
// marks each result for one cycle and the receiver cannot stall
// ----------------------------------------------------------------------------
// fermi_weighted_bond_current_kernel_core
// Fermi-weighted bond current kernel: queued command front end, sequenced
// eigenstate back end and the configuration registers.
// ----------------------------------------------------------------------------
module fermi_weighted_bond_current_kernel_core import fwbc_pkg::*; #(
  parameter int SITES  = 64,
  parameter int EIGENS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         eigen_index_i,
  input  logic [5:0]         site_a_i,
  input  logic [5:0]         site_b_i,
  input  logic signed [31:0] value_re_i,
  input  logic signed [31:0] value_im_i,
  input  logic signed [15:0] disp_x_i,
  input  logic signed [15:0] disp_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [47:0] susc_x_up_o,
  output logic signed [47:0] susc_y_up_o,
  output logic signed [47:0] susc_x_dn_o,
  output logic signed [47:0] susc_y_dn_o
);

  cfg_t cfg_q;
  cmd_t head;
  logic avail;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_temp   <= 1'b1;
      cfg_q.inv_temp    <= 32'd65536;
      cfg_q.eigen_count <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZERO_TEMP:   cfg_q.zero_temp   <= cfg_data_i[0];
        CFG_INV_TEMP:    cfg_q.inv_temp    <= cfg_data_i;
        CFG_EIGEN_COUNT: cfg_q.eigen_count <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  fwbc_front #(
    .SITES  (SITES),
    .EIGENS (EIGENS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .eigen_index_i (eigen_index_i),
    .site_a_i      (site_a_i),
    .site_b_i      (site_b_i),
    .value_re_i    (value_re_i),
    .value_im_i    (value_im_i),
    .disp_x_i      (disp_x_i),
    .disp_y_i      (disp_y_i),
    .pop_i         (pop),
    .avail_o       (avail),
    .head_o        (head)
  );

  fwbc_back #(
    .SITES  (SITES),
    .EIGENS (EIGENS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (avail),
    .head_i      (head),
    .pop_o       (pop),
    .done_o      (done_o),
    .susc_x_up_o (susc_x_up_o),
    .susc_y_up_o (susc_y_up_o),
    .susc_x_dn_o (susc_x_dn_o),
    .susc_y_dn_o (susc_y_dn_o)
  );

endmodule
`default_nettype wire

@@ hdl/fwbc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwbc_front
// Command intake: range checks each word, drops loads that fall outside the
// stores and parks the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fwbc_front import fwbc_pkg::*; #(
  parameter int SITES,
  parameter int EIGENS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         eigen_index_i,
  input  logic [5:0]         site_a_i,
  input  logic [5:0]         site_b_i,
  input  logic signed [31:0] value_re_i,
  input  logic signed [31:0] value_im_i,
  input  logic signed [15:0] disp_x_i,
  input  logic signed [15:0] disp_y_i,
  input  logic               pop_i,
  output logic               avail_o,
  output cmd_t               head_o
);

  localparam int QDepth = 2;

  cmd_t       q_mem_q [QDepth];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       accept;
  logic       push;
  logic       is_query;
  logic       eig_ok;
  logic       sa_ok;
  logic       sb_ok;
  cmd_t       cmd;

  assign busy_o   = (cnt_q == 2'(QDepth));
  assign accept   = start_i && !busy_o;
  assign is_query = (func_e'(func_i) == FN_QUERY);
  assign eig_ok   = ({26'd0, eigen_index_i} < 32'(EIGENS));
  assign sa_ok    = ({26'd0, site_a_i} < 32'(SITES));
  assign sb_ok    = ({26'd0, site_b_i} < 32'(SITES));

  always_comb begin
    cmd.func = func_e'(func_i);
    cmd.eig  = eigen_index_i;
    cmd.re   = value_re_i;
    cmd.im   = value_im_i;
    cmd.dx   = disp_x_i;
    cmd.dy   = disp_y_i;
    if (is_query) begin
      cmd.ok = sa_ok && sb_ok;
    end else begin
      cmd.ok = eig_ok && (sa_ok || (func_e'(func_i) == FN_LOAD_EIG));
    end
    cmd.sa = (is_query && !cmd.ok) ? 6'd0 : site_a_i;
    cmd.sb = (is_query && !cmd.ok) ? 6'd0 : site_b_i;
  end

  assign push    = accept && (cmd.ok || is_query);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = q_mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= cmd;
    end
  end

endmodule
`default_nettype wire

@@ hdl/fwbc_term.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwbc_term
// Five-stage term pipeline for one spin: conj(psi_i)*psi_j, projection on the
// amplitude, weighting by the occupation.
// ----------------------------------------------------------------------------
module fwbc_term import fwbc_pkg::*; (
  input  logic               clk_i,
  input  logic [63:0]        pi_i,
  input  logic [63:0]        pj_i,
  input  logic [16:0]        f_i,
  input  logic signed [31:0] ar_i,
  input  logic signed [31:0] ai_i,
  output logic signed [51:0] term_o
);

  logic signed [31:0] pir;
  logic signed [31:0] pii;
  logic signed [31:0] pjr;
  logic signed [31:0] pji;
  logic signed [63:0] rr_q;
  logic signed [63:0] ii_q;
  logic signed [63:0] ri_q;
  logic signed [63:0] ir_q;
  logic signed [31:0] cr_q;
  logic signed [31:0] ci_q;
  logic signed [63:0] ac_q;
  logic signed [63:0] bc_q;
  logic signed [40:0] r_q;
  logic [16:0]        f2_q;
  logic [16:0]        f3_q;
  logic [16:0]        f4_q;
  logic [16:0]        f5_q;
  logic signed [58:0] fr;
  logic signed [51:0] term_q;

  assign pir = $signed(pi_i[31:0]);
  assign pii = $signed(pi_i[63:32]);
  assign pjr = $signed(pj_i[31:0]);
  assign pji = $signed(pj_i[63:32]);
  assign fr  = r_q * $signed({1'b0, f5_q});

  always_ff @(posedge clk_i) begin
    rr_q   <= pir * pjr;
    ii_q   <= pii * pji;
    ri_q   <= pir * pji;
    ir_q   <= pii * pjr;
    f2_q   <= f_i;
    cr_q   <= sat32(41'(rr_q >>> 24) + 41'(ii_q >>> 24));
    ci_q   <= sat32(41'(ri_q >>> 24) - 41'(ir_q >>> 24));
    f3_q   <= f2_q;
    ac_q   <= ar_i * cr_q;
    bc_q   <= ai_i * ci_q;
    f4_q   <= f3_q;
    r_q    <= 41'(ac_q >>> 24) - 41'(bc_q >>> 24);
    f5_q   <= f4_q;
    // 2*r*f >> 8
    term_q <= 52'(fr >>> 7);
  end

  assign term_o = term_q;

endmodule
`default_nettype wire

@@ hdl/fwbc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwbc_back
// Execution side: eigenvector and occupation stores, occupation computation,
// eigenstate sequencer, per-spin accumulators and displacement scaling.
// ----------------------------------------------------------------------------
module fwbc_back import fwbc_pkg::*; #(
  parameter int SITES,
  parameter int EIGENS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               avail_i,
  input  cmd_t               head_i,
  output logic               pop_o,
  output logic               done_o,
  output logic signed [47:0] susc_x_up_o,
  output logic signed [47:0] susc_y_up_o,
  output logic signed [47:0] susc_x_dn_o,
  output logic signed [47:0] susc_y_dn_o
);

  localparam int Depth = SITES * EIGENS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EW    = (EIGENS > 1) ? $clog2(EIGENS) : 1;
  localparam int CW    = $clog2(EIGENS + 1);

  logic [63:0] up_mem  [Depth];
  logic [63:0] dn_mem  [Depth];
  logic [16:0] occ_mem [EIGENS];

  back_state_e        state_q, state_d;
  cmd_t               cur_q;
  logic [EW-1:0]      e_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      cnt_clamp;
  logic [63:0]        mag_q;
  logic [31:0]        abs_e;
  logic [5:0]         vpipe_q;
  logic [5:0]         lpipe_q;
  logic               issue;
  logic               last;
  logic               take_query;

  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr_i;
  logic [AW-1:0]      rd_addr_j;
  logic               up_we;
  logic               dn_we;
  logic               occ_we;
  logic [7:0]         lut_k;
  logic [16:0]        lut_w;
  logic [16:0]        occ_val;

  logic [63:0]        upi_q;
  logic [63:0]        upj_q;
  logic [63:0]        dni_q;
  logic [63:0]        dnj_q;
  logic [16:0]        f1_q;
  logic [63:0]        upi;
  logic [63:0]        upj;
  logic [63:0]        dni;
  logic [63:0]        dnj;
  logic signed [51:0] term_up;
  logic signed [51:0] term_dn;

  logic signed [63:0] acc_up_q;
  logic signed [63:0] acc_dn_q;
  logic signed [47:0] s_up_q;
  logic signed [47:0] s_dn_q;
  logic signed [63:0] pxu_q;
  logic signed [63:0] pyu_q;
  logic signed [63:0] pxd_q;
  logic signed [63:0] pyd_q;
  logic signed [47:0] oxu_q;
  logic signed [47:0] oyu_q;
  logic signed [47:0] oxd_q;
  logic signed [47:0] oyd_q;
  logic               done_q;

  assign cnt_clamp = ({25'd0, cfg_i.eigen_count} > 32'(EIGENS)) ?
                     CW'(EIGENS) : CW'(cfg_i.eigen_count);

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    issue      = 1'b0;
    last       = 1'b0;
    take_query = 1'b0;
    up_we      = 1'b0;
    dn_we      = 1'b0;
    occ_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          unique case (head_i.func) inside
            FN_LOAD_EIG: begin
              state_d = ST_OCC_MUL;
            end
            FN_LOAD_UP: begin
              up_we = 1'b1;
            end
            FN_LOAD_DN: begin
              dn_we = 1'b1;
            end
            FN_QUERY: begin
              take_query = 1'b1;
              state_d    = (cnt_clamp == '0) ? ST_SAT : ST_ISSUE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_OCC_MUL: begin
        state_d = ST_OCC_WR;
      end
      ST_OCC_WR: begin
        occ_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        last  = ((32'(e_q) + 32'd1) == 32'(cnt_q));
        if (last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (vpipe_q[5] && lpipe_q[5]) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vpipe_q <= '0;
      lpipe_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vpipe_q <= {vpipe_q[4:0], issue};
      lpipe_q <= {lpipe_q[4:0], issue && last};
      done_q  <= (state_q == ST_OUT);
    end
  end

  // occupation
  assign abs_e   = cur_q.re[31] ? (~cur_q.re + 32'd1) : cur_q.re;
  assign lut_k   = (|mag_q[63:44]) ? 8'hff : mag_q[43:36];
  assign lut_w   = LogisticLut[lut_k];

  always_comb begin
    if (cfg_i.zero_temp) begin
      if (cur_q.re[31]) begin
        occ_val = OneQ16;
      end else if (cur_q.re == 32'sd0) begin
        occ_val = HalfQ16;
      end else begin
        occ_val = 17'd0;
      end
    end else begin
      occ_val = cur_q.re[31] ? (OneQ16 - lut_w) : lut_w;
    end
  end

  assign wr_addr   = AW'(32'(head_i.eig) * 32'(SITES) + 32'(head_i.sa));
  assign rd_addr_i = AW'(32'(e_q) * 32'(SITES) + 32'(cur_q.sa));
  assign rd_addr_j = AW'(32'(e_q) * 32'(SITES) + 32'(cur_q.sb));

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      up_mem[wr_addr] <= {head_i.im, head_i.re};
    end
    upi_q <= up_mem[rd_addr_i];
    upj_q <= up_mem[rd_addr_j];
  end

  always_ff @(posedge clk_i) begin
    if (dn_we) begin
      dn_mem[wr_addr] <= {head_i.im, head_i.re};
    end
    dni_q <= dn_mem[rd_addr_i];
    dnj_q <= dn_mem[rd_addr_j];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[EW'(cur_q.eig)] <= occ_val;
    end
    f1_q <= occ_mem[e_q];
  end

  // sequencer payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (take_query) begin
      cnt_q <= cnt_clamp;
      e_q   <= '0;
    end else if (issue) begin
      e_q <= e_q + 1'b1;
    end
    if (state_q == ST_OCC_MUL) begin
      mag_q <= abs_e * cfg_i.inv_temp;
    end
  end

  assign upi = cur_q.ok ? upi_q : 64'd0;
  assign upj = cur_q.ok ? upj_q : 64'd0;
  assign dni = cur_q.ok ? dni_q : 64'd0;
  assign dnj = cur_q.ok ? dnj_q : 64'd0;

  fwbc_term u_term_up (
    .clk_i  (clk_i),
    .pi_i   (upi),
    .pj_i   (upj),
    .f_i    (f1_q),
    .ar_i   (cur_q.re),
    .ai_i   (cur_q.im),
    .term_o (term_up)
  );

  fwbc_term u_term_dn (
    .clk_i  (clk_i),
    .pi_i   (dni),
    .pj_i   (dnj),
    .f_i    (f1_q),
    .ar_i   (cur_q.re),
    .ai_i   (cur_q.im),
    .term_o (term_dn)
  );

  always_ff @(posedge clk_i) begin
    if (take_query) begin
      acc_up_q <= '0;
      acc_dn_q <= '0;
    end else if (vpipe_q[5]) begin
      acc_up_q <= acc_up_q + 64'(term_up);
      acc_dn_q <= acc_dn_q + 64'(term_dn);
    end
    if (state_q == ST_SAT) begin
      s_up_q <= sat48(acc_up_q);
      s_dn_q <= sat48(acc_dn_q);
    end
    if (state_q == ST_SCALE) begin
      pxu_q <= s_up_q * cur_q.dx;
      pyu_q <= s_up_q * cur_q.dy;
      pxd_q <= s_dn_q * cur_q.dx;
      pyd_q <= s_dn_q * cur_q.dy;
    end
    if (state_q == ST_OUT) begin
      oxu_q <= sat48(pxu_q >>> 8);
      oyu_q <= sat48(pyu_q >>> 8);
      oxd_q <= sat48(pxd_q >>> 8);
      oyd_q <= sat48(pyd_q >>> 8);
    end
  end

  assign done_o      = done_q;
  assign susc_x_up_o = oxu_q;
  assign susc_y_up_o = oyu_q;
  assign susc_x_dn_o = oxd_q;
  assign susc_y_dn_o = oyd_q;

endmodule
`default_nettype wire

@@ hdl/fwbc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fwbc_assert
// Port-level checks of the kernel: clean state out of reset, single-cycle
// result strobe, queue fill only through an accepted word.
// ----------------------------------------------------------------------------
module fwbc_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (!busy_o && !done_o))
    else $error("busy or done right after reset");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done held for two cycles");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy rose without an accepted word");

endmodule

bind fermi_weighted_bond_current_kernel_core fwbc_assert u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
`default_nettype wire

@@ tb/fwbc_checker.sv @@
// ----------------------------------------------------------------------------
// fwbc_checker
// Watches the command, configuration and result ports of the bond current
// kernel, keeps its own copy of the eigenvector and occupation stores and
// predicts every bond query result, then compares each done word field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module fwbc_checker import fwbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         func_i,
  input  logic [5:0]         eigen_index_i,
  input  logic [5:0]         site_a_i,
  input  logic [5:0]         site_b_i,
  input  logic signed [31:0] value_re_i,
  input  logic signed [31:0] value_im_i,
  input  logic signed [15:0] disp_x_i,
  input  logic signed [15:0] disp_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               done_i,
  input  logic signed [47:0] susc_x_up_i,
  input  logic signed [47:0] susc_y_up_i,
  input  logic signed [47:0] susc_x_dn_i,
  input  logic signed [47:0] susc_y_dn_i,
  output int                 pending_o,
  output int                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [47:0] x_up;
    logic signed [47:0] y_up;
    logic signed [47:0] x_dn;
    logic signed [47:0] y_dn;
  } bond_word_t;

  bit [63:0]   up_store [4096];
  bit [63:0]   dn_store [4096];
  bit [16:0]   occ_store [64];
  bit [16:0]   logistic_w [256];
  bit          zero_temp;
  bit [31:0]   beta;
  bit [6:0]    term_count;
  bond_word_t  bond_q [$];
  int          errors;

  assign pending_o = bond_q.size();
  assign errors_o  = errors;

  initial begin
    bit [127:0]      g;
    longint unsigned den;
    g = 128'd1 << 32;
    for (int k = 0; k < 256; k++) begin
      den = 64'd4294967296 + g[63:0];
      logistic_w[k] = 17'(((g[63:0] << 16) + (den >> 1)) / den);
      g = (g * 128'd4034748382 + (128'd1 << 31)) >> 32;
    end
    errors = 0;
  end

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic bit [16:0] occupancy(longint e);
    longint unsigned mag;
    longint unsigned k;
    if (zero_temp) begin
      if (e < 0) return OneQ16;
      if (e == 0) return HalfQ16;
      return 17'd0;
    end
    mag = longint'(e < 0 ? -e : e) * longint'({32'd0, beta});
    k = mag >> 36;
    if (k > 255) k = 255;
    return (e < 0) ? OneQ16 - logistic_w[k] : logistic_w[k];
  endfunction

  function automatic longint spin_sum(bit down, int i, int j, longint ar, longint ai,
                                      int cnt);
    longint acc, pir, pii, pjr, pji, cr, ci, r;
    bit [63:0] vi, vj;
    acc = 0;
    for (int e = 0; e < cnt; e++) begin
      vi = down ? dn_store[e * 64 + i] : up_store[e * 64 + i];
      vj = down ? dn_store[e * 64 + j] : up_store[e * 64 + j];
      pir = $signed(vi[31:0]);
      pii = $signed(vi[63:32]);
      pjr = $signed(vj[31:0]);
      pji = $signed(vj[63:32]);
      cr = clip(((pir * pjr) >>> 24) + ((pii * pji) >>> 24), 32);
      ci = clip(((pir * pji) >>> 24) - ((pii * pjr) >>> 24), 32);
      r = ((ar * cr) >>> 24) - ((ai * ci) >>> 24);
      acc += (2 * r * longint'({47'd0, occ_store[e]})) >>> 8;
    end
    return clip(acc, 48);
  endfunction

  function automatic logic signed [47:0] scaled(longint s, longint d);
    return 48'(clip((s * d) >>> 8, 48));
  endfunction

  task automatic compare(string name, logic signed [47:0] exp_v, logic signed [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d got %0d at %0t", name, exp_v, act_v, $realtime);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_temp  <= 1'b1;
      beta       <= 32'd65536;
      term_count <= 7'd64;
      bond_q.delete();
    end else begin
      bond_word_t w;
      longint     su, sd;
      int         cnt;
      if (done_i) begin
        if (bond_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result word with nothing pending at %0t", $realtime);
        end else begin
          w = bond_q.pop_front();
          compare("susc_x_up", w.x_up, susc_x_up_i);
          compare("susc_y_up", w.y_up, susc_y_up_i);
          compare("susc_x_dn", w.x_dn, susc_x_dn_i);
          compare("susc_y_dn", w.y_dn, susc_y_dn_i);
        end
      end
      if (start_i && !busy_i) begin
        case (func_e'(func_i))
          FN_LOAD_EIG: occ_store[eigen_index_i] = occupancy(longint'(value_re_i));
          FN_LOAD_UP:  up_store[eigen_index_i * 64 + site_a_i] = {value_im_i, value_re_i};
          FN_LOAD_DN:  dn_store[eigen_index_i * 64 + site_a_i] = {value_im_i, value_re_i};
          FN_QUERY: begin
            cnt = (term_count > 64) ? 64 : term_count;
            su = spin_sum(1'b0, site_a_i, site_b_i, value_re_i, value_im_i, cnt);
            sd = spin_sum(1'b1, site_a_i, site_b_i, value_re_i, value_im_i, cnt);
            w.x_up = scaled(su, disp_x_i);
            w.y_up = scaled(su, disp_y_i);
            w.x_dn = scaled(sd, disp_x_i);
            w.y_dn = scaled(sd, disp_y_i);
            bond_q.push_back(w);
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ZERO_TEMP:   zero_temp  <= cfg_data_i[0];
          CFG_INV_TEMP:    beta       <= cfg_data_i;
          CFG_EIGEN_COUNT: term_count <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/fermi_weighted_bond_current_kernel_core_test.sv @@
// ----------------------------------------------------------------------------
// fermi_weighted_bond_current_kernel_core_test
// Fills the stores for a small set of sites, then runs directed and random
// loads and bond queries over several occupation and term count settings,
// with random sender gaps; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fermi_weighted_bond_current_kernel_core_test import fwbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CfgUnused = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         func_i;
  logic [5:0]         eigen_index_i;
  logic [5:0]         site_a_i;
  logic [5:0]         site_b_i;
  logic signed [31:0] value_re_i;
  logic signed [31:0] value_im_i;
  logic signed [15:0] disp_x_i;
  logic signed [15:0] disp_y_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               done_o;
  logic signed [47:0] susc_x_up_o;
  logic signed [47:0] susc_y_up_o;
  logic signed [47:0] susc_x_dn_o;
  logic signed [47:0] susc_y_dn_o;
  int                 pending;
  int                 errors;
  bit                 gaps_on;
  bit [5:0]           bond_sites [4] = '{6'd0, 6'd1, 6'd2, 6'd63};

  fermi_weighted_bond_current_kernel_core DUT (.*);

  fwbc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .eigen_index_i, .site_a_i,
    .site_b_i, .value_re_i, .value_im_i, .disp_x_i, .disp_y_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .done_i(done_o), .susc_x_up_i(susc_x_up_o), .susc_y_up_i(susc_y_up_o),
    .susc_x_dn_i(susc_x_dn_o), .susc_y_dn_i(susc_y_dn_o), .pending_o(pending),
    .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] rand_value();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return 32'hffffffff;
      4, 5, 6, 7, 8, 9: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(func_e f, bit [5:0] eig, bit [5:0] sa, bit [5:0] sb,
                       logic [31:0] re, logic [31:0] im, logic [15:0] dx, logic [15:0] dy);
    start_i       <= 1'b1;
    func_i        <= f;
    eigen_index_i <= eig;
    site_a_i      <= sa;
    site_b_i      <= sb;
    value_re_i    <= re;
    value_im_i    <= im;
    disp_x_i      <= dx;
    disp_y_i      <= dy;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic query(bit [5:0] sa, bit [5:0] sb, logic [31:0] re, logic [31:0] im,
                       logic [15:0] dx, logic [15:0] dy);
    issue(FN_QUERY, 6'($urandom), sa, sb, re, im, dx, dy);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_regs(bit zt, logic [31:0] b, logic [6:0] cnt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ZERO_TEMP;
    cfg_data_i <= {31'($urandom), zt};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INV_TEMP;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_EIGEN_COUNT;
    cfg_data_i <= {25'($urandom), cnt};
    @(posedge clk_i);
    cfg_idx_i  <= CfgUnused;
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_items(int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9)
        query(bond_sites[$urandom_range(0, 3)], bond_sites[$urandom_range(0, 3)],
              rand_value(), rand_value(), 16'($urandom), 16'($urandom));
      else if (sel < 13)
        issue(FN_LOAD_UP, 6'($urandom), bond_sites[$urandom_range(0, 3)], 6'($urandom),
              rand_value(), rand_value(), 16'($urandom), 16'($urandom));
      else if (sel < 17)
        issue(FN_LOAD_DN, 6'($urandom), bond_sites[$urandom_range(0, 3)], 6'($urandom),
              rand_value(), rand_value(), 16'($urandom), 16'($urandom));
      else if (sel < 19)
        issue(FN_LOAD_EIG, 6'($urandom), 6'($urandom), 6'($urandom),
              rand_value(), $urandom, 16'($urandom), 16'($urandom));
      else
        issue(func_e'($urandom_range(1, 2)), 6'($urandom), 6'($urandom), 6'($urandom),
              $urandom, $urandom, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    func_i        = '0;
    eigen_index_i = '0;
    site_a_i      = '0;
    site_b_i      = '0;
    value_re_i    = '0;
    value_im_i    = '0;
    disp_x_i      = '0;
    disp_y_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(1'b1, 32'd65536, 7'd64);

    // fill every store entry that a query can reach
    for (int e = 0; e < 64; e++) begin
      issue(FN_LOAD_EIG, 6'(e), 6'($urandom), 6'($urandom), rand_value(), $urandom,
            16'd0, 16'd0);
      for (int s = 0; s < 4; s++) begin
        issue(FN_LOAD_UP, 6'(e), bond_sites[s], 6'($urandom), rand_value(), rand_value(),
              16'd0, 16'd0);
        issue(FN_LOAD_DN, 6'(e), bond_sites[s], 6'($urandom), rand_value(), rand_value(),
              16'd0, 16'd0);
      end
    end

    // step occupation at negative, zero and positive energy
    issue(FN_LOAD_EIG, 6'd0, 6'd0, 6'd0, 32'hffffffff, 32'd0, 16'd0, 16'd0);
    issue(FN_LOAD_EIG, 6'd1, 6'd0, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0);
    issue(FN_LOAD_EIG, 6'd63, 6'd63, 6'd63, 32'd1, 32'hffffffff, 16'd0, 16'd0);
    issue(FN_LOAD_UP, 6'd63, 6'd63, 6'd63, 32'h7fffffff, 32'h80000000, 16'd0, 16'd0);
    issue(FN_LOAD_DN, 6'd63, 6'd63, 6'd63, 32'h80000000, 32'h7fffffff, 16'd0, 16'd0);
    query(6'd0, 6'd63, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000);
    query(6'd63, 6'd63, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff);
    query(6'd63, 6'd0, 32'h01000000, 32'd0, 16'h0100, 16'hff00);
    query(6'd1, 6'd2, 32'd0, 32'd0, 16'h7fff, 16'h7fff);
    query(6'd2, 6'd1, 32'hffffffff, 32'h00000001, 16'hffff, 16'd0);
    drain();

    // no terms at all
    set_regs(1'b0, 32'd0, 7'd0);
    query(6'd0, 6'd1, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff);
    random_items(40);
    drain();

    // coldest beta and a term count past the store depth
    set_regs(1'b0, 32'hffffffff, 7'd127);
    issue(FN_LOAD_EIG, 6'd2, 6'd0, 6'd0, 32'h80000000, 32'd0, 16'd0, 16'd0);
    issue(FN_LOAD_EIG, 6'd3, 6'd0, 6'd0, 32'h7fffffff, 32'd0, 16'd0, 16'd0);
    issue(FN_LOAD_EIG, 6'd4, 6'd0, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0);
    random_items(40);
    drain();

    set_regs(1'b0, 32'd65536, 7'd1);
    random_items(40);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_regs(1'($urandom), ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20),
               ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16)));
      if (p == 5) gaps_on = 1'b0;
      random_items(100);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
